[rtl/lens_distortion_point_mapper_defines.svh]
// Assertion helpers for the RTL.
`ifndef LENS_DISTORTION_POINT_MAPPER_DEFINES_SVH
`define LENS_DISTORTION_POINT_MAPPER_DEFINES_SVH

// Same-cycle implication.
`define LDPM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ldpm: implication check failed");

// Next-cycle implication.
`define LDPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ldpm: next-cycle check failed");

`endif

[rtl/ldpm_pkg.sv]
package ldpm_pkg;

   localparam int PW       = 24;  // pixel field width, signed Q16.8
   localparam int FW       = 24;  // focal width, unsigned Q16.8
   localparam int KW       = 32;  // coefficient width, signed Q4.28
   localparam int QW       = 63;  // internal signed Q.28 word
   localparam int FRAC     = 28;
   localparam int DIV_BITS = 54;
   localparam int DIV_STG  = DIV_BITS / 2;
   localparam int MUL_LAT  = 5;
   localparam int CSR_IW   = 3;
   localparam int CSR_DW   = 48;

   typedef logic signed [QW-1:0] q_type;

   localparam q_type LIM_Q = {1'b0, {(QW-1){1'b1}}};
   localparam q_type ONE_Q = q_type'(64'd1 << FRAC);

   localparam logic signed [QW:0] LIM_W = {2'b00, {(QW-1){1'b1}}};

   typedef enum logic [CSR_IW-1:0] {
      CSR_FOCAL_X   = 3'd0,
      CSR_FOCAL_Y   = 3'd1,
      CSR_PRINCIPAL = 3'd2,
      CSR_K1        = 3'd3,
      CSR_K2        = 3'd4,
      CSR_K3        = 3'd5,
      CSR_P1        = 3'd6,
      CSR_P2        = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic signed [PW-1:0] warped_col;
      logic signed [PW-1:0] warped_row;
      logic                 clipped;
   } res_type;

   // Saturating sum in the internal word.
   function automatic q_type sat_add(q_type a, q_type b);
      logic signed [QW:0] s;
      s = {a[QW-1], a} + {b[QW-1], b};
      if (s > LIM_W) begin
         return LIM_Q;
      end else if (s < -LIM_W) begin
         return -LIM_Q;
      end
      return s[QW-1:0];
   endfunction

   // A zero focal length behaves as one LSB.
   function automatic logic [FW-1:0] eff_focal(logic [FW-1:0] f);
      return (f == '0) ? FW'(1) : f;
   endfunction

   // One restoring division step: {quotient bit, new remainder}.
   function automatic logic [FW:0] div_step(logic [FW-1:0] rem, logic nb,
                                            logic [FW-1:0] f);
      logic [FW:0] t;
      logic [FW:0] d;
      t = {rem, nb};
      d = t - {1'b0, f};
      if (t >= {1'b0, f}) begin
         return {1'b1, d[FW-1:0]};
      end
      return {1'b0, t[FW-1:0]};
   endfunction

   // Sign-extend a coefficient into the internal word.
   function automatic q_type coef_q(logic [KW-1:0] k);
      return {{(QW-KW){k[KW-1]}}, k};
   endfunction

endpackage

[rtl/ldpm_req_if.sv]
interface ldpm_req_if import ldpm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic signed [PW-1:0] point_col;
   logic signed [PW-1:0] point_row;

   modport source (output valid, output point_col, output point_row, input ready);
   modport sink   (input valid, input point_col, input point_row, output ready);
endinterface

[rtl/ldpm_rsp_if.sv]
interface ldpm_rsp_if import ldpm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic signed [PW-1:0] warped_col;
   logic signed [PW-1:0] warped_row;
   logic                 clipped;

   modport source (output valid, output warped_col, output warped_row,
                   output clipped, input ready);
   modport sink   (input valid, input warped_col, input warped_row,
                   input clipped, output ready);
endinterface

[rtl/lens_distortion_point_mapper.sv]
// Channel   Dir  Payload                               Handshake
// req_chan  in   point_col, point_row (s24 Q16.8)       valid/ready
// rsp_chan  out  warped_col, warped_row (s24), clipped  valid/ready
// csr_*     in   index 3 b, data 48 b                   write enable
//
// One point per clock while the skid stage is empty.
// The 54-bit normalizing divide runs over 27 stages at two quotient bits a stage.
// Synchronous reset empties the pipeline and loads the register defaults.
// The output register plus a one-beat skid stage keep accepting while a
// result waits; the whole pipeline holds only once the skid stage is full.
module lens_distortion_point_mapper import ldpm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   ldpm_req_if.sink          req_chan,
   ldpm_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

`include "lens_distortion_point_mapper_defines.svh"

   localparam int TAIL = 6 * MUL_LAT + 4;       // stages from x/y to result
   localparam int VLAT = 3 + DIV_STG + TAIL;
   localparam int XD   = 4 * MUL_LAT + 2;       // x/y wait for the gain
   localparam int TD   = 2 * MUL_LAT + 4;       // tangential terms wait
   localparam int RD   = MUL_LAT;
   localparam int GD   = MUL_LAT - 1;

   // configuration
   logic [FW-1:0]   focal_x_ff, focal_y_ff;
   logic [2*FW-1:0] pp_ff;
   logic [KW-1:0]   k1_ff, k2_ff, k3_ff, p1_ff, p2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff <= FW'(256);
         focal_y_ff <= FW'(256);
         pp_ff      <= '0;
         k1_ff      <= '0;
         k2_ff      <= '0;
         k3_ff      <= '0;
         p1_ff      <= '0;
         p2_ff      <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_FOCAL_X:   focal_x_ff <= csr_wdata[FW-1:0];
            CSR_FOCAL_Y:   focal_y_ff <= csr_wdata[FW-1:0];
            CSR_PRINCIPAL: pp_ff      <= csr_wdata[2*FW-1:0];
            CSR_K1:        k1_ff      <= csr_wdata[KW-1:0];
            CSR_K2:        k2_ff      <= csr_wdata[KW-1:0];
            CSR_K3:        k3_ff      <= csr_wdata[KW-1:0];
            CSR_P1:        p1_ff      <= csr_wdata[KW-1:0];
            CSR_P2:        p2_ff      <= csr_wdata[KW-1:0];
            default: ;
         endcase
      end
   end

   logic [FW-1:0] fe     [2];
   logic [FW-1:0] cen    [2];
   q_type         fq     [2];
   logic [PW-1:0] pt     [2];

   assign fe[0]  = eff_focal(focal_x_ff);
   assign fe[1]  = eff_focal(focal_y_ff);
   assign cen[0] = pp_ff[2*FW-1:FW];
   assign cen[1] = pp_ff[FW-1:0];
   assign fq[0]  = q_type'({{(QW-FW){1'b0}}, fe[0]});
   assign fq[1]  = q_type'({{(QW-FW){1'b0}}, fe[1]});
   assign pt[0]  = req_chan.point_col;
   assign pt[1]  = req_chan.point_row;

   // flow control
   logic            en;
   logic [VLAT-1:0] vld_ff;
   logic            skid_vld_ff, rsp_vld_ff;
   res_type         skid_ff, rsp_ff, res_ff;
   logic            out_free;

   assign en             = !skid_vld_ff;
   assign req_chan.ready = en && !reset;
   assign out_free       = !rsp_vld_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[VLAT-2:0], req_chan.valid};
      end
   end

   // offset, sign split and divide
   logic signed [PW+1:0] d_ff     [2];
   logic signed [PW+1:0] d_in     [2];
   logic [PW:0]          ud       [2];
   logic [FW-1:0]        drem_ff  [2][DIV_STG+1];
   logic [DIV_BITS-1:0]  dnum_ff  [2][DIV_STG+1];
   logic [DIV_BITS-1:0]  dq_ff    [2][DIV_STG+1];
   logic                 dneg_ff  [2][DIV_STG+1];
   logic [FW-1:0]        drem_in  [2][DIV_STG];
   logic [DIV_BITS-1:0]  dq_in    [2][DIV_STG];
   q_type                x_ff     [2];
   q_type                x_in     [2];

   always_comb begin
      logic [FW:0] s1;
      logic [FW:0] s2;
      for (int l = 0; l < 2; l++) begin
         d_in[l] = {{2{pt[l][PW-1]}}, pt[l]} - $signed({2'b00, cen[l]});
         ud[l]   = d_ff[l][PW+1] ? (PW+1)'(0) - d_ff[l][PW:0] : d_ff[l][PW:0];
         // ud is a magnitude below 2^25, so the low 25 bits of the negation suffice
         for (int k = 0; k < DIV_STG; k++) begin
            s1 = div_step(drem_ff[l][k], dnum_ff[l][k][DIV_BITS-1], fe[l]);
            s2 = div_step(s1[FW-1:0], dnum_ff[l][k][DIV_BITS-2], fe[l]);
            drem_in[l][k] = s2[FW-1:0];
            dq_in[l][k]   = {dq_ff[l][k][DIV_BITS-3:0], s1[FW], s2[FW]};
         end
         x_in[l] = dneg_ff[l][DIV_STG]
                   ? -q_type'({{(QW-DIV_BITS){1'b0}}, dq_ff[l][DIV_STG]})
                   :  q_type'({{(QW-DIV_BITS){1'b0}}, dq_ff[l][DIV_STG]});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 2; l++) begin
            d_ff[l]       <= d_in[l];
            drem_ff[l][0] <= '0;
            dq_ff[l][0]   <= '0;
            dneg_ff[l][0] <= d_ff[l][PW+1];
            dnum_ff[l][0] <= {1'b0, ud[l], {FRAC{1'b0}}}
                             + {{(DIV_BITS-FW+1){1'b0}}, fe[l][FW-1:1]};
            for (int k = 0; k < DIV_STG; k++) begin
               drem_ff[l][k+1] <= drem_in[l][k];
               dq_ff[l][k+1]   <= dq_in[l][k];
               dneg_ff[l][k+1] <= dneg_ff[l][k];
               dnum_ff[l][k+1] <= {dnum_ff[l][k][DIV_BITS-3:0], 2'b00};
            end
            x_ff[l] <= x_in[l];
         end
      end
   end

   // distortion datapath
   q_type sq [2], xg [2], px [2];
   q_type xy, r4, r6, k1r2, k2r4, k3r6, p1xy, p2xy, p2s, p1s;
   q_type r2_ff, xy2_ff, g1_ff, g2_ff, g_ff, p1xy_d_ff, p2xy_d_ff;
   q_type dbl_ff [2], s_ff [2], t_ff [2], xd_ff [2];
   q_type xdl_ff [2][XD];
   q_type tdl_ff [2][TD];
   q_type r2dl_ff [RD];
   q_type g1dl_ff [GD];
   q_type g2dl_ff [GD];

   genvar gl;
   for (gl = 0; gl < 2; gl++) begin : g_lane
      ldpm_smul u_sq (.clock(clock), .en(en), .a(x_ff[gl]), .b(x_ff[gl]), .p(sq[gl]));
      ldpm_smul u_g  (.clock(clock), .en(en), .a(xdl_ff[gl][XD-1]), .b(g_ff),
                      .p(xg[gl]));
      ldpm_smul u_pj (.clock(clock), .en(en), .a(xd_ff[gl]), .b(fq[gl]), .p(px[gl]));
   end

   ldpm_smul u_xy   (.clock(clock), .en(en), .a(x_ff[0]), .b(x_ff[1]), .p(xy));
   ldpm_smul u_r4   (.clock(clock), .en(en), .a(r2_ff), .b(r2_ff), .p(r4));
   ldpm_smul u_k1   (.clock(clock), .en(en), .a(coef_q(k1_ff)), .b(r2_ff), .p(k1r2));
   ldpm_smul u_p1xy (.clock(clock), .en(en), .a(coef_q(p1_ff)), .b(xy2_ff), .p(p1xy));
   ldpm_smul u_p2xy (.clock(clock), .en(en), .a(coef_q(p2_ff)), .b(xy2_ff), .p(p2xy));
   ldpm_smul u_p2s  (.clock(clock), .en(en), .a(coef_q(p2_ff)), .b(s_ff[0]), .p(p2s));
   ldpm_smul u_p1s  (.clock(clock), .en(en), .a(coef_q(p1_ff)), .b(s_ff[1]), .p(p1s));
   ldpm_smul u_r6   (.clock(clock), .en(en), .a(r4), .b(r2dl_ff[RD-1]), .p(r6));
   ldpm_smul u_k2   (.clock(clock), .en(en), .a(coef_q(k2_ff)), .b(r4), .p(k2r4));
   ldpm_smul u_k3   (.clock(clock), .en(en), .a(coef_q(k3_ff)), .b(r6), .p(k3r6));

   logic signed [QW:0] rp [2];
   res_type            res_in;

   always_comb begin
      res_in.clipped = 1'b0;
      res_in.warped_col = '0;
      res_in.warped_row = '0;
      for (int l = 0; l < 2; l++) begin
         rp[l] = {px[l][QW-1], px[l]} + $signed({{(QW-FW+1){1'b0}}, cen[l]});
      end
      if (rp[0] > (QW+1)'(8388607)) begin
         res_in.warped_col = {1'b0, {(PW-1){1'b1}}};
         res_in.clipped    = 1'b1;
      end else if (rp[0] < -(QW+1)'(8388608)) begin
         res_in.warped_col = {1'b1, {(PW-1){1'b0}}};
         res_in.clipped    = 1'b1;
      end else begin
         res_in.warped_col = rp[0][PW-1:0];
      end
      if (rp[1] > (QW+1)'(8388607)) begin
         res_in.warped_row = {1'b0, {(PW-1){1'b1}}};
         res_in.clipped    = 1'b1;
      end else if (rp[1] < -(QW+1)'(8388608)) begin
         res_in.warped_row = {1'b1, {(PW-1){1'b0}}};
         res_in.clipped    = 1'b1;
      end else begin
         res_in.warped_row = rp[1][PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r2_ff     <= sat_add(sq[0], sq[1]);
         xy2_ff    <= sat_add(xy, xy);
         p1xy_d_ff <= p1xy;
         p2xy_d_ff <= p2xy;
         t_ff[0]   <= sat_add(p1xy_d_ff, p2s);
         t_ff[1]   <= sat_add(p1s, p2xy_d_ff);
         g1_ff     <= sat_add(ONE_Q, k1r2);
         g2_ff     <= sat_add(g1dl_ff[GD-1], k2r4);
         g_ff      <= sat_add(g2dl_ff[GD-1], k3r6);
         r2dl_ff[0] <= r2_ff;
         g1dl_ff[0] <= g1_ff;
         g2dl_ff[0] <= g2_ff;
         for (int i = 1; i < RD; i++) begin
            r2dl_ff[i] <= r2dl_ff[i-1];
         end
         for (int i = 1; i < GD; i++) begin
            g1dl_ff[i] <= g1dl_ff[i-1];
            g2dl_ff[i] <= g2dl_ff[i-1];
         end
         for (int l = 0; l < 2; l++) begin
            dbl_ff[l]    <= sat_add(sq[l], sq[l]);
            s_ff[l]      <= sat_add(r2_ff, dbl_ff[l]);
            xd_ff[l]     <= sat_add(xg[l], tdl_ff[l][TD-1]);
            xdl_ff[l][0] <= x_ff[l];
            tdl_ff[l][0] <= t_ff[l];
            for (int i = 1; i < XD; i++) begin
               xdl_ff[l][i] <= xdl_ff[l][i-1];
            end
            for (int i = 1; i < TD; i++) begin
               tdl_ff[l][i] <= tdl_ff[l][i-1];
            end
         end
         res_ff <= res_in;
      end
   end

   // output register and skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (out_free) begin
            rsp_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end
      end else if (vld_ff[VLAT-1]) begin
         if (out_free) begin
            rsp_vld_ff <= 1'b1;
         end else begin
            skid_vld_ff <= 1'b1;
         end
      end else if (out_free) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (out_free) begin
            rsp_ff <= skid_ff;
         end
      end else if (vld_ff[VLAT-1]) begin
         if (out_free) begin
            rsp_ff <= res_ff;
         end else begin
            skid_ff <= res_ff;
         end
      end
   end

   assign rsp_chan.valid      = rsp_vld_ff;
   assign rsp_chan.warped_col = rsp_ff.warped_col;
   assign rsp_chan.warped_row = rsp_ff.warped_row;
   assign rsp_chan.clipped    = rsp_ff.clipped;

   `LDPM_ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_vld_ff, rsp_vld_ff)
   `LDPM_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset,
                     !rsp_vld_ff && !skid_vld_ff && !vld_ff[VLAT-1])
   `LDPM_ASSERT_NEXT(a_full_skid_holds_tail, clock, reset,
                     skid_vld_ff && vld_ff[VLAT-1] && !rsp_chan.ready, vld_ff[VLAT-1])

endmodule

[rtl/ldpm_smul.sv]
// Signed Q.28 product, rounded half away from zero, saturated; five stages.
module ldpm_smul import ldpm_pkg::*; (
   input  logic  clock,
   input  logic  en,
   input  q_type a,
   input  q_type b,
   output q_type p
);

   localparam int MW = QW - 1;   // magnitude width
   localparam int HW = MW / 2;   // half width
   localparam int PWD = 2 * MW;  // full product width

   logic [MUL_LAT-2:0] neg_ff;
   logic [MW-1:0]      am_ff, bm_ff;
   logic [2*HW-1:0]    p00_ff, p01_ff, p10_ff, p11_ff;
   logic [2*HW:0]      mid_ff, lo_ff;
   logic [2*HW-1:0]    hi_ff;
   logic [PWD-1:0]     full_ff;
   q_type              p_ff;

   q_type              a_abs, b_abs, p_in;
   logic [MW-1:0]      mag;

   assign a_abs = a[QW-1] ? -a : a;
   assign b_abs = b[QW-1] ? -b : b;

   always_comb begin
      if (|full_ff[PWD-1:MW+FRAC]) begin
         mag = {MW{1'b1}};
      end else begin
         mag = full_ff[MW+FRAC-1:FRAC];
      end
      p_in = neg_ff[MUL_LAT-2] ? -q_type'({1'b0, mag}) : q_type'({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0] <= a[QW-1] ^ b[QW-1];
         for (int i = 1; i < MUL_LAT-1; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
         am_ff   <= a_abs[MW-1:0];
         bm_ff   <= b_abs[MW-1:0];
         p00_ff  <= am_ff[HW-1:0]  * bm_ff[HW-1:0];
         p01_ff  <= am_ff[HW-1:0]  * bm_ff[MW-1:HW];
         p10_ff  <= am_ff[MW-1:HW] * bm_ff[HW-1:0];
         p11_ff  <= am_ff[MW-1:HW] * bm_ff[MW-1:HW];
         mid_ff  <= {1'b0, p01_ff} + {1'b0, p10_ff};
         lo_ff   <= {1'b0, p00_ff} + (2*HW+1)'(1 << (FRAC-1));
         hi_ff   <= p11_ff;
         full_ff <= {hi_ff, {MW{1'b0}}} + PWD'({mid_ff, {HW{1'b0}}}) + PWD'(lo_ff);
         p_ff    <= p_in;
      end
   end

   assign p = p_ff;

endmodule
